FILE: src/etrb_pkg.sv
// Shared types and constants for the event trace ring buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package etrb_pkg;

  // Number of trace entries in the ring (supported range 2 to 64).
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Fill count and returned count fit 0..64.
  localparam int unsigned CNT_W = 7;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  // Request opcodes.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         event_kind;
    logic [15:0]        proc_id;
    logic signed [31:0] extra_word;
    logic [7:0]         read_limit;
  } in_req_t;

  typedef struct packed {
    logic               entry_valid;
    logic [31:0]        stamp_out;
    logic [7:0]         kind_out;
    logic [15:0]        pid_out;
    logic signed [31:0] extra_out;
    logic [CNT_W-1:0]   returned_count;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic [7:0]         kind;
    logic [15:0]        pid;
    logic signed [31:0] extra;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rec_we;     // store the incoming event
    logic rd_start;   // latch count and start pointer of a read request
    logic rd_issue;   // read one entry from the ring
    logic out_load;   // move the fetched entry into the output register
    logic out_empty;  // load the result of an empty read
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_read;     // incoming request is a read
    logic n_zero;       // incoming read would return no entries
    logic remain_zero;  // no entries left to fetch
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_EMPTY = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: src/etrb_ctrl.sv
// Controller state machine of the event trace ring buffer.
// Depends on etrb_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module etrb_ctrl import etrb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   rd_valid_q, rd_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   advance;

  // The output register can take a new value when it is empty or drains now.
  assign advance = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (status_i.req_read) begin
            cmd_o.rd_start = 1'b1;
            state_d = status_i.n_zero ? ST_EMPTY : ST_READ;
          end else begin
            cmd_o.rec_we = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.out_load = advance && rd_valid_q;
        cmd_o.rd_issue = !status_i.remain_zero && (!rd_valid_q || advance);
        if (status_i.remain_zero && !rd_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (advance) begin
          cmd_o.out_empty = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_valid_d = rd_valid_q;
    if (cmd_o.rd_issue) begin
      rd_valid_d = 1'b1;
    end else if (cmd_o.out_load) begin
      rd_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (cmd_o.out_load || cmd_o.out_empty) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/etrb_dpath.sv
// Datapath of the event trace ring buffer: trace memory, pointers, counters
// and output register. Depends on etrb_pkg; commanded by etrb_ctrl.
`default_nettype none

module etrb_dpath import etrb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_req_t  in_req_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_status_t    status_o,
  output out_rsp_t      out_rsp_o
);

  entry_t           mem [DEPTH];
  entry_t           rd_data_q;
  logic             rd_last_q;

  logic [IDX_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      seq_q, seq_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic [CNT_W-1:0] n_q;
  out_rsp_t         out_q;

  logic [CNT_W-1:0] n_req;
  logic [IDX_W-1:0] start_idx;
  logic [IDX_W-1:0] n_idx;

  // Entries returned: the smaller of fill count and limit (fill never exceeds DEPTH).
  always_comb begin
    if ({1'b0, in_req_i.read_limit} < {{(9 - CNT_W){1'b0}}, fill_q}) begin
      n_req = in_req_i.read_limit[CNT_W-1:0];
    end else begin
      n_req = fill_q;
    end
  end

  // Oldest of the n newest entries: write pointer minus n, modulo DEPTH.
  // When n equals DEPTH the start is the write pointer itself.
  always_comb begin
    n_idx = n_req[IDX_W-1:0];
    if (n_req == DEPTH_CNT) begin
      start_idx = wp_q;
    end else if ({{(CNT_W - IDX_W){1'b0}}, wp_q} >= n_req) begin
      start_idx = wp_q - n_idx;
    end else begin
      start_idx = IDX_W'(CNT_W'(wp_q) + DEPTH_CNT - n_req);
    end
  end

  assign status_o.req_read    = (in_req_i.op == OP_READ);
  assign status_o.n_zero      = (n_req == '0);
  assign status_o.remain_zero = (remain_q == '0);

  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    seq_d    = seq_q;
    rd_ptr_d = rd_ptr_q;
    remain_d = remain_q;
    if (cmd_i.rec_we) begin
      wp_d  = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
      seq_d = seq_q + 32'd1;
      if (fill_q != DEPTH_CNT) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (cmd_i.rd_start) begin
      rd_ptr_d = start_idx;
      remain_d = n_req;
    end else if (cmd_i.rd_issue) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
      remain_d = remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      seq_q    <= '0;
      rd_ptr_q <= '0;
      remain_q <= '0;
    end else begin
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      seq_q    <= seq_d;
      rd_ptr_q <= rd_ptr_d;
      remain_q <= remain_d;
    end
  end

  // Trace memory: one write port for records, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_we) begin
      mem[wp_q] <= '{stamp: seq_q, kind: in_req_i.event_kind,
                     pid: in_req_i.proc_id, extra: in_req_i.extra_word};
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_ptr_q];
      rd_last_q <= (remain_q == CNT_W'(1));
    end
  end

  // Output register and request count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) begin
      n_q <= n_req;
    end
    if (cmd_i.out_load) begin
      out_q.entry_valid    <= 1'b1;
      out_q.stamp_out      <= rd_data_q.stamp;
      out_q.kind_out       <= rd_data_q.kind;
      out_q.pid_out        <= rd_data_q.pid;
      out_q.extra_out      <= rd_data_q.extra;
      out_q.returned_count <= n_q;
      out_q.last           <= rd_last_q;
    end else if (cmd_i.out_empty) begin
      out_q <= '{entry_valid: 1'b0, stamp_out: '0, kind_out: '0, pid_out: '0,
                 extra_out: '0, returned_count: '0, last: 1'b1};
    end
  end

  assign out_rsp_o = out_q;

endmodule

`default_nettype wire

FILE: src/event_trace_ring_buffer.sv
// Top level of the event trace ring buffer.
// Depends on etrb_pkg, etrb_ctrl and etrb_dpath.
`default_nettype none

// The block keeps the DEPTH most recent trace events in a circular memory.
// A record request (op = 0) stores event kind, process id and extra word,
// stamped with a free-running 32-bit sequence counter; records are accepted
// back to back, also while a read result still waits on the output. A read
// request (op = 1) returns the n newest entries, oldest first, where n is
// the smaller of the fill count and read_limit; each result carries n in
// returned_count and the final one has last set. A read of an empty store
// or with a zero limit gives a single result with entry_valid low and last
// high. A read is accepted in the idle state, then streams one entry per
// cycle while the output is not stalled, each fetched via the registered
// memory read port into the output register; input requests are stalled
// until the controller is back in idle. There is no clearing pass after
// reset: entries are read only after being written.

module event_trace_ring_buffer import etrb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_rsp_t      out_rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing of requests and of the output handshake.
  etrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage, pointers and the output register.
  etrb_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire
